// ----- rtl/tthg_pkg.sv -----
// ============================================================================
// tthg_pkg
// Shared types and constants for the thermal tier hysteresis guard.
// ============================================================================
package tthg_pkg;

    localparam int TEMP_W   = 9;
    localparam int TIER_W   = 2;
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int APB_DW   = 32;
    localparam int APB_AW   = REG_IDX_W + 2;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [TIER_W-1:0]        t_tier;
    typedef logic [REG_IDX_W-1:0]     t_reg_idx;

    // Tier codes.
    localparam t_tier TIER_COOL = 2'd0;
    localparam t_tier TIER_WARM = 2'd1;
    localparam t_tier TIER_HOT  = 2'd2;

    // Register indexes.
    localparam t_reg_idx REG_HOT_BAT  = 3'd0;
    localparam t_reg_idx REG_HOT_CPU  = 3'd1;
    localparam t_reg_idx REG_WARM_BAT = 3'd2;
    localparam t_reg_idx REG_WARM_CPU = 3'd3;
    localparam t_reg_idx REG_CLR_BAT  = 3'd4;
    localparam t_reg_idx REG_CLR_CPU  = 3'd5;
    localparam t_reg_idx REG_COOL_BAT = 3'd6;
    localparam t_reg_idx REG_COOL_CPU = 3'd7;

    // Reset values of the threshold registers, in register order.
    localparam t_temp RST_HOT_BAT  = 9'sd48;
    localparam t_temp RST_HOT_CPU  = 9'sd75;
    localparam t_temp RST_WARM_BAT = 9'sd45;
    localparam t_temp RST_WARM_CPU = 9'sd70;
    localparam t_temp RST_CLR_BAT  = 9'sd44;
    localparam t_temp RST_CLR_CPU  = 9'sd68;
    localparam t_temp RST_COOL_BAT = 9'sd42;
    localparam t_temp RST_COOL_CPU = 9'sd64;

    // All eight thresholds as seen by the tier logic.
    typedef struct packed {
        logic signed [TEMP_W-1:0] hot_bat;
        logic signed [TEMP_W-1:0] hot_cpu;
        logic signed [TEMP_W-1:0] warm_bat;
        logic signed [TEMP_W-1:0] warm_cpu;
        logic signed [TEMP_W-1:0] clr_bat;
        logic signed [TEMP_W-1:0] clr_cpu;
        logic signed [TEMP_W-1:0] cool_bat;
        logic signed [TEMP_W-1:0] cool_cpu;
    } t_limits;

endpackage

// ----- rtl/thermal_tier_hysteresis_guard.sv -----
// ============================================================================
// thermal_tier_hysteresis_guard
// Three-level thermal throttle tier (cool, warm, hot) with hysteresis.
// ============================================================================
//
//  Channel  | Signals                                        | Direction
//  ---------+------------------------------------------------+----------
//  in       | i_in_valid, o_in_ready, i_cpu_temperature,     | sink
//           | i_battery_temperature                          |
//  out      | o_out_valid, i_out_ready, o_tier,              | source
//           | o_tier_changed                                 |
//  config   | psel, penable, pwrite, paddr, pwdata, prdata,  | APB slave
//           | pready                                         |
//
//  A sample accepted at one edge is held in an input register; at the next
//  edge where the result register is free (or being drained) it is judged,
//  the tier register is updated and the result is registered, which raises
//  output valid. One transaction per cycle is sustained while the output is
//  not stalled, set by the single tier register feeding back through the
//  comparator logic. When the output is stalled the input register still
//  takes one more transaction before o_in_ready drops. Reset is synchronous
//  and active low; it returns the tier to cool and the thresholds to their
//  default values.
//
module thermal_tier_hysteresis_guard
    import tthg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Input sample channel.
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_temp             i_cpu_temperature,
    input  t_temp             i_battery_temperature,

    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_tier             o_tier,
    output logic              o_tier_changed,

    // Threshold configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_limits w_limits;

    // Input register stage.
    logic  r_in_valid;
    t_temp r_cpu;
    t_temp r_bat;

    // Tier state and result register.
    t_tier r_tier;
    logic  r_out_valid;
    t_tier r_out_tier;
    logic  r_out_changed;

    t_tier w_next_tier;
    logic  w_changed;
    logic  w_advance;

    assign pready = 1'b1;

    tthg_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .o_limits (w_limits)
    );

    tthg_tier u_tier (
        .i_cpu     (r_cpu),
        .i_bat     (r_bat),
        .i_prev    (r_tier),
        .i_limits  (w_limits),
        .o_next    (w_next_tier),
        .o_changed (w_changed)
    );

    // The held sample moves on whenever the result register can take it.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cpu <= i_cpu_temperature;
            r_bat <= i_battery_temperature;
        end
    end

    // The tier register is the only state that carries from one sample to the
    // next; it updates exactly when a result is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tier      <= TIER_COOL;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_tier      <= w_next_tier;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_tier    <= w_next_tier;
            r_out_changed <= w_changed;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_tier         = r_out_tier;
    assign o_tier_changed = r_out_changed;

endmodule

// ----- rtl/tthg_regs.sv -----
// ============================================================================
// tthg_regs
// APB-style register file holding the eight temperature thresholds.
// ============================================================================
module tthg_regs
    import tthg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output t_limits           o_limits
);

    t_temp    r_regs [NUM_REGS];
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = paddr[APB_AW-1:2];
    assign w_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[REG_HOT_BAT]  <= RST_HOT_BAT;
            r_regs[REG_HOT_CPU]  <= RST_HOT_CPU;
            r_regs[REG_WARM_BAT] <= RST_WARM_BAT;
            r_regs[REG_WARM_CPU] <= RST_WARM_CPU;
            r_regs[REG_CLR_BAT]  <= RST_CLR_BAT;
            r_regs[REG_CLR_CPU]  <= RST_CLR_CPU;
            r_regs[REG_COOL_BAT] <= RST_COOL_BAT;
            r_regs[REG_COOL_CPU] <= RST_COOL_CPU;
        end else if (w_wr) begin
            r_regs[w_idx] <= pwdata[TEMP_W-1:0];
        end
    end

    // Reads return the threshold sign-extended to the bus width.
    assign prdata = {{(APB_DW-TEMP_W){r_regs[w_idx][TEMP_W-1]}}, r_regs[w_idx]};

    assign o_limits.hot_bat  = r_regs[REG_HOT_BAT];
    assign o_limits.hot_cpu  = r_regs[REG_HOT_CPU];
    assign o_limits.warm_bat = r_regs[REG_WARM_BAT];
    assign o_limits.warm_cpu = r_regs[REG_WARM_CPU];
    assign o_limits.clr_bat  = r_regs[REG_CLR_BAT];
    assign o_limits.clr_cpu  = r_regs[REG_CLR_CPU];
    assign o_limits.cool_bat = r_regs[REG_COOL_BAT];
    assign o_limits.cool_cpu = r_regs[REG_COOL_CPU];

endmodule

// ----- rtl/tthg_tier.sv -----
// ============================================================================
// tthg_tier
// Next-tier decision: compares one sample against the thresholds.
// ============================================================================
module tthg_tier
    import tthg_pkg::*;
(
    input  t_temp   i_cpu,
    input  t_temp   i_bat,
    input  t_tier   i_prev,
    input  t_limits i_limits,
    output t_tier   o_next,
    output logic    o_changed
);

    t_temp hot_bat, hot_cpu, warm_bat, warm_cpu;
    t_temp clr_bat, clr_cpu, cool_bat, cool_cpu;
    logic  to_hot, to_warm, may_clear, may_cool, stay_warm;

    assign hot_bat  = i_limits.hot_bat;
    assign hot_cpu  = i_limits.hot_cpu;
    assign warm_bat = i_limits.warm_bat;
    assign warm_cpu = i_limits.warm_cpu;
    assign clr_bat  = i_limits.clr_bat;
    assign clr_cpu  = i_limits.clr_cpu;
    assign cool_bat = i_limits.cool_bat;
    assign cool_cpu = i_limits.cool_cpu;

    assign to_hot    = (i_bat >= hot_bat)  || (i_cpu >= hot_cpu);
    assign to_warm   = (i_bat >= warm_bat) || (i_cpu >= warm_cpu);
    assign may_clear = (i_bat <= clr_bat)  && (i_cpu <= clr_cpu);
    assign may_cool  = (i_bat <= cool_bat) && (i_cpu <= cool_cpu);
    assign stay_warm = (i_bat >= cool_bat) || (i_cpu >  cool_cpu);

    always_comb begin
        unique case (i_prev)
            TIER_HOT: begin
                if (may_clear) begin
                    o_next = stay_warm ? TIER_WARM : TIER_COOL;
                end else begin
                    o_next = TIER_HOT;
                end
            end
            TIER_WARM: begin
                if (to_hot) begin
                    o_next = TIER_HOT;
                end else if (may_cool) begin
                    o_next = TIER_COOL;
                end else begin
                    o_next = TIER_WARM;
                end
            end
            default: begin
                // Cool, and the unused code, which behaves as cool.
                if (to_hot) begin
                    o_next = TIER_HOT;
                end else if (to_warm) begin
                    o_next = TIER_WARM;
                end else begin
                    o_next = TIER_COOL;
                end
            end
        endcase
    end

    assign o_changed = (o_next != i_prev);

endmodule

// ----- sim/tb_thermal_tier_hysteresis_guard.sv -----
// ============================================================================
// tb_thermal_tier_hysteresis_guard
// Self-checking testbench for the three-level thermal throttle tier block.
// ============================================================================
// Samples go in through a valid/ready channel. A tier predictor runs on its
// own copy of the eight thresholds and of the current tier. Each accepted
// sample queues one expected result, and a checker compares every result
// transaction with the oldest entry in that queue. The thresholds are written
// and read back over the APB port, but only while no result is outstanding.
// The stimulus has three parts. A directed pass walks every tier transition
// at the exact limits and at the extremes of the temperature range. A second
// pass uses extreme and inverted threshold settings. Random traffic then
// follows several threshold sets, with temperatures that wander around the
// limits so that the hysteresis paths are taken often.
// ============================================================================
module tb_thermal_tier_hysteresis_guard;
    import tthg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_tier tier;
        logic  changed;
    } tier_result_t;

    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 270;
    localparam int EXTREME_ITEMS    = 40;
    localparam int SETTLE_CYCLES    = 6;

    // DUT ports. Every input has a known value from time zero.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_temp             i_cpu_temperature = '0;
    t_temp             i_battery_temperature = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_tier             o_tier;
    logic              o_tier_changed;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Predictor state: thresholds as the block should hold them, and the tier.
    t_temp          thresh [NUM_REGS];
    t_temp          plan [NUM_REGS];
    t_tier          tier_now;
    tier_result_t   pending_tiers [$];

    // Random walk positions used to keep temperatures near the limits.
    int walk_cpu;
    int walk_bat;

    // Traffic shaping. When a steady flag is set that side never idles.
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    int sink_hold   = 0;

    int errors      = 0;
    int n_samples   = 0;
    int n_results   = 0;
    int n_changes   = 0;
    int n_writes    = 0;

    thermal_tier_hysteresis_guard dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_cpu_temperature     (i_cpu_temperature),
        .i_battery_temperature (i_battery_temperature),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_tier                (o_tier),
        .o_tier_changed        (o_tier_changed),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Safety net in case a handshake never completes.
    initial begin
        #10_000_000;
        $display("Timeout at %0t with %0d results still outstanding.", $time,
                 pending_tiers.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tier predictor
    // ------------------------------------------------------------------------

    // Next tier for one sample. Hot is left only when both temperatures are
    // at or below their clear limits. Leaving hot lands in warm while the
    // battery is still at or above its cool limit or the CPU is above its
    // cool limit. Warm falls to cool only with both temperatures at or below
    // their cool limits. An unused tier code would behave like cool.
    function automatic t_tier judge_tier(t_tier cur, t_temp cpu, t_temp bat);
        logic to_hot;
        t_tier nxt;
        to_hot = (bat >= thresh[REG_HOT_BAT]) || (cpu >= thresh[REG_HOT_CPU]);
        case (cur)
            TIER_HOT: begin
                nxt = TIER_HOT;
                if (bat <= thresh[REG_CLR_BAT] && cpu <= thresh[REG_CLR_CPU]) begin
                    if (bat >= thresh[REG_COOL_BAT] || cpu > thresh[REG_COOL_CPU])
                        nxt = TIER_WARM;
                    else
                        nxt = TIER_COOL;
                end
            end
            TIER_WARM: begin
                if (to_hot)
                    nxt = TIER_HOT;
                else if (bat <= thresh[REG_COOL_BAT] && cpu <= thresh[REG_COOL_CPU])
                    nxt = TIER_COOL;
                else
                    nxt = TIER_WARM;
            end
            default: begin
                if (to_hot)
                    nxt = TIER_HOT;
                else if (bat >= thresh[REG_WARM_BAT] || cpu >= thresh[REG_WARM_CPU])
                    nxt = TIER_WARM;
                else
                    nxt = TIER_COOL;
            end
        endcase
        return nxt;
    endfunction

    function automatic t_temp clamp_temp(int v);
        int c;
        c = v;
        if (c > 255)
            c = 255;
        if (c < -256)
            c = -256;
        return t_temp'(c);
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 2);
        else if (r < 92)
            return $urandom_range(3, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (sink_steady) begin
            i_out_ready <= 1'b1;
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if ($urandom_range(0, 2) != 0) begin
            i_out_ready <= 1'b1;
            sink_hold   <= $urandom_range(0, 12);
        end else begin
            i_out_ready <= 1'b0;
            sink_hold   <= pick_pause();
        end
    end

    // Every result transaction must match the oldest outstanding prediction.
    always @(posedge i_clk) begin : check_results
        tier_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_tiers.size() == 0) begin
                $display("%0t: result with nothing expected: tier %0d changed %0b",
                         $time, o_tier, o_tier_changed);
                errors++;
            end else begin
                want = pending_tiers.pop_front();
                n_results++;
                if (want.changed)
                    n_changes++;
                if (o_tier !== want.tier) begin
                    $display("%0t: tier mismatch: expected %0d actual %0d",
                             $time, want.tier, o_tier);
                    errors++;
                end
                if (o_tier_changed !== want.changed) begin
                    $display("%0t: tier_changed mismatch: expected %0b actual %0b",
                             $time, want.changed, o_tier_changed);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers. All of them start and end at a falling edge.
    // ------------------------------------------------------------------------

    // Offers one sample, waits for the transaction and queues its prediction.
    task automatic push_sample(t_temp cpu, t_temp bat);
        int gap;
        t_tier nxt;
        gap = src_steady ? 0 : (($urandom_range(0, 1) == 0) ? 0 : pick_pause());
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid            <= 1'b1;
        i_cpu_temperature     <= cpu;
        i_battery_temperature <= bat;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        nxt = judge_tier(tier_now, cpu, bat);
        pending_tiers.push_back('{tier: nxt, changed: (nxt != tier_now)});
        tier_now = nxt;
        n_samples++;
        @(negedge i_clk);
    endtask

    // Stops offering samples and waits until every result is back. Each
    // sample yields exactly one result, so an empty queue means the block is
    // idle; the settle wait after that is only a safety margin.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_tiers.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_read(t_reg_idx idx, t_temp want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[TEMP_W-1:0] !== want) begin
            $display("%0t: register %0d readback: expected %0d actual %0d",
                     $time, idx, want, $signed(prdata[TEMP_W-1:0]));
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Writes one threshold, mirrors it into the predictor and reads it back.
    task automatic apb_write(t_reg_idx idx, t_temp val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DW-TEMP_W){val[TEMP_W-1]}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        thresh[idx] = val;
        n_writes++;
        @(negedge i_clk);
        apb_read(idx, val);
    endtask

    task automatic program_plan();
        for (int i = 0; i < NUM_REGS; i++)
            apb_write(t_reg_idx'(i), plan[i]);
    endtask

    // Most samples wander in small steps around the thresholds, sometimes
    // jumping onto one of them; a quarter are drawn from the whole range.
    task automatic make_sample(output t_temp cpu, output t_temp bat);
        if ($urandom_range(0, 3) == 0) begin
            cpu = t_temp'($urandom_range(0, 511));
            bat = t_temp'($urandom_range(0, 511));
        end else begin
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 3))
                    0: walk_cpu = int'(thresh[REG_HOT_CPU]);
                    1: walk_cpu = int'(thresh[REG_WARM_CPU]);
                    2: walk_cpu = int'(thresh[REG_CLR_CPU]);
                    default: walk_cpu = int'(thresh[REG_COOL_CPU]);
                endcase
            end
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 3))
                    0: walk_bat = int'(thresh[REG_HOT_BAT]);
                    1: walk_bat = int'(thresh[REG_WARM_BAT]);
                    2: walk_bat = int'(thresh[REG_CLR_BAT]);
                    default: walk_bat = int'(thresh[REG_COOL_BAT]);
                endcase
            end
            cpu = clamp_temp(walk_cpu + int'($urandom_range(0, 8)) - 4);
            bat = clamp_temp(walk_bat + int'($urandom_range(0, 8)) - 4);
            walk_cpu = int'(cpu);
            walk_bat = int'(bat);
        end
    endtask

    task automatic send_random(int count);
        t_temp cpu;
        t_temp bat;
        for (int i = 0; i < count; i++) begin
            make_sample(cpu, bat);
            push_sample(cpu, bat);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // After reset every threshold reads back at its default value.
    task automatic test_reset_defaults();
        thresh[REG_HOT_BAT]  = RST_HOT_BAT;
        thresh[REG_HOT_CPU]  = RST_HOT_CPU;
        thresh[REG_WARM_BAT] = RST_WARM_BAT;
        thresh[REG_WARM_CPU] = RST_WARM_CPU;
        thresh[REG_CLR_BAT]  = RST_CLR_BAT;
        thresh[REG_CLR_CPU]  = RST_CLR_CPU;
        thresh[REG_COOL_BAT] = RST_COOL_BAT;
        thresh[REG_COOL_CPU] = RST_COOL_CPU;
        tier_now = TIER_COOL;
        for (int i = 0; i < NUM_REGS; i++)
            apb_read(t_reg_idx'(i), thresh[i]);
    endtask

    // With default thresholds, walks every transition at the exact limits:
    // cool to warm and back, warm to hot, hot clearing into warm through
    // either the battery or the CPU condition, hot clearing into cool, and
    // the range extremes of both temperatures.
    task automatic test_directed_transitions();
        t_temp cpu_pts [20] = '{-256,  69,  70,  64,   0,  65,  75,  68,   0,  65,
                                 255,  69,   0,  64,  -1, 255, -256, -256, 74,  74};
        t_temp bat_pts [20] = '{-256,  44,   0,  42,  45,   0,   0,  44,  48,   0,
                                 255,   0,  45,  41,  -1, -256, 255, -256, 47,  47};
        for (int i = 0; i < 20; i++)
            push_sample(cpu_pts[i], bat_pts[i]);
        drain_results();
    endtask

    // Extreme threshold settings: all at the bottom, all at the top, and an
    // inverted set where the hot and warm limits sit below the clear and
    // cool limits. No ordering among the limits is enforced.
    task automatic test_threshold_extremes();
        for (int s = 0; s < 3; s++) begin
            for (int i = 0; i < NUM_REGS; i++)
                plan[i] = (s == 0) ? t_temp'(-256) : t_temp'(255);
            if (s == 2) begin
                plan[REG_HOT_BAT]  = t_temp'(-256);
                plan[REG_HOT_CPU]  = t_temp'(-256);
                plan[REG_WARM_BAT] = t_temp'(-256);
                plan[REG_WARM_CPU] = t_temp'(-256);
            end
            program_plan();
            send_random(EXTREME_ITEMS);
            drain_results();
        end
    endtask

    // Random traffic over several threshold sets. The first set restores the
    // defaults; later ones are either sensibly ordered (cool below clear
    // below warm below hot, with small spacing) or drawn at random. One phase
    // runs its first half with no idling on either side, and in another the
    // sender holds off midway until every result has come back.
    task automatic test_random_traffic();
        int cbase;
        int bbase;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                plan[REG_HOT_BAT]  = RST_HOT_BAT;
                plan[REG_HOT_CPU]  = RST_HOT_CPU;
                plan[REG_WARM_BAT] = RST_WARM_BAT;
                plan[REG_WARM_CPU] = RST_WARM_CPU;
                plan[REG_CLR_BAT]  = RST_CLR_BAT;
                plan[REG_CLR_CPU]  = RST_CLR_CPU;
                plan[REG_COOL_BAT] = RST_COOL_BAT;
                plan[REG_COOL_CPU] = RST_COOL_CPU;
            end else if (p % 3 == 2) begin
                for (int i = 0; i < NUM_REGS; i++)
                    plan[i] = t_temp'($urandom_range(0, 511));
            end else begin
                cbase = int'($urandom_range(0, 440)) - 230;
                bbase = int'($urandom_range(0, 440)) - 230;
                plan[REG_COOL_CPU] = clamp_temp(cbase);
                plan[REG_CLR_CPU]  = clamp_temp(cbase + int'($urandom_range(0, 6)));
                plan[REG_WARM_CPU] = clamp_temp(int'(plan[REG_CLR_CPU])
                                                + int'($urandom_range(0, 6)));
                plan[REG_HOT_CPU]  = clamp_temp(int'(plan[REG_WARM_CPU])
                                                + int'($urandom_range(0, 8)));
                plan[REG_COOL_BAT] = clamp_temp(bbase);
                plan[REG_CLR_BAT]  = clamp_temp(bbase + int'($urandom_range(0, 6)));
                plan[REG_WARM_BAT] = clamp_temp(int'(plan[REG_CLR_BAT])
                                                + int'($urandom_range(0, 6)));
                plan[REG_HOT_BAT]  = clamp_temp(int'(plan[REG_WARM_BAT])
                                                + int'($urandom_range(0, 8)));
            end
            program_plan();
            walk_cpu = int'(thresh[REG_COOL_CPU]);
            walk_bat = int'(thresh[REG_COOL_BAT]);
            if (p == 3) begin
                src_steady  = 1'b1;
                sink_steady = 1'b1;
            end
            send_random(ITEMS_PER_PHASE / 2);
            src_steady  = 1'b0;
            sink_steady = 1'b0;
            if (p == 1)
                drain_results();
            send_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        walk_cpu = 0;
        walk_bat = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_directed_transitions();
        test_threshold_extremes();
        test_random_traffic();

        // All stimulus is in; let the last results and the pipeline settle.
        drain_results();

        $display("Run covered %0d samples and %0d checked results with %0d tier changes,",
                 n_samples, n_results, n_changes);
        $display("across %0d threshold writes with readback; %0d mismatches seen.",
                 n_writes, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
